FILE: src/gap_fill_max_subarray_core_assert.svh
// ---------------------------------------------------------------------------
// gap fill max subarray: assertion macros
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// The synthesis branch leaves each macro empty.
// ---------------------------------------------------------------------------
`ifndef GAP_FILL_MAX_SUBARRAY_CORE_ASSERT_SVH
`define GAP_FILL_MAX_SUBARRAY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GFMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfms assertion failed");

// next-cycle implication
`define GFMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gfms assertion failed");

`else

`define GFMS_ASSERT_IMP(lbl, ante, cons)
`define GFMS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: src/gfms_pkg.sv
// ---------------------------------------------------------------------------
// gfms_pkg
// Shared constants, codes and control types of the gap fill / max subarray core.
// ---------------------------------------------------------------------------
`default_nettype none

package gfms_pkg;

  // default configuration
  localparam int MAX_GAP     = 32;
  localparam int SAMPLE_BITS = 32;

  // fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int VALUE_W  = 48;
  localparam int KIND_W   = 2;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_MAX    = 2'd1,
    KIND_ERR    = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_FILL,
    S_SAMPLE,
    S_TRAIL,
    S_MAX
  } state_t;

  // result source select
  typedef enum logic [2:0] {
    SEL_FILL,
    SEL_SAMPLE,
    SEL_TRAIL,
    SEL_MAX,
    SEL_ERR
  } sel_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pend_inc;
    logic issue;
    sel_t sel;
    logic end_flag;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pend_zero;
    logic pend_one;
    logic pend_full;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: src/gfms_in_if.sv
// ---------------------------------------------------------------------------
// gfms_in_if
// Input word channel: one sample with its missing and last flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface gfms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [gfms_pkg::SAMPLE_W-1:0] sample;
  logic                                  missing;
  logic                                  last;

  modport source (output valid, output sample, output missing, output last, input ready);
  modport sink   (input valid, input sample, input missing, input last, output ready);
endinterface

`default_nettype wire

FILE: src/gfms_out_if.sv
// ---------------------------------------------------------------------------
// gfms_out_if
// Result word channel: value, kind and end of run marker.
// ---------------------------------------------------------------------------
`default_nettype none

interface gfms_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gfms_pkg::VALUE_W-1:0] value;
  logic [gfms_pkg::KIND_W-1:0]         kind;
  logic                                 end_of_run;

  modport source (output valid, output value, output kind, output end_of_run, input ready);
  modport sink   (input valid, input value, input kind, input end_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/gfms_ctrl.sv
// ---------------------------------------------------------------------------
// gfms_ctrl
// Sequencer: accepts input words and steps through gap errors, fills, the present
// sample, trailing fills and the final maximum sum, one result per free output slot.
// ---------------------------------------------------------------------------
`default_nettype none

module gfms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_missing,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire gfms_pkg::status_t st,
  output gfms_pkg::cmd_t         cmd
);

  gfms_pkg::state_t state_r, state_nxt;
  logic             last_r, last_nxt;

  // state and last flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfms_pkg::S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.pend_inc = 1'b0;
    cmd.issue    = 1'b0;
    cmd.sel      = gfms_pkg::SEL_SAMPLE;
    cmd.end_flag = 1'b0;
    case (state_r)
      gfms_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          last_nxt = in_last;
          if (in_missing) begin
            if (st.pend_full) begin
              state_nxt = gfms_pkg::S_ERR;
            end else begin
              cmd.pend_inc = 1'b1;
              state_nxt    = in_last ? gfms_pkg::S_TRAIL : gfms_pkg::S_IDLE;
            end
          end else begin
            state_nxt = st.pend_zero ? gfms_pkg::S_SAMPLE : gfms_pkg::S_FILL;
          end
        end
      end
      gfms_pkg::S_ERR: begin
        cmd.sel      = gfms_pkg::SEL_ERR;
        cmd.end_flag = !last_r;
        if (st.out_free) begin
          cmd.issue = 1'b1;
          state_nxt = last_r ? gfms_pkg::S_TRAIL : gfms_pkg::S_IDLE;
        end
      end
      gfms_pkg::S_FILL: begin
        cmd.sel = gfms_pkg::SEL_FILL;
        if (st.out_free) begin
          cmd.issue = 1'b1;
          if (st.pend_one) state_nxt = gfms_pkg::S_SAMPLE;
        end
      end
      gfms_pkg::S_SAMPLE: begin
        cmd.sel      = gfms_pkg::SEL_SAMPLE;
        cmd.end_flag = !last_r;
        if (st.out_free) begin
          cmd.issue = 1'b1;
          state_nxt = last_r ? gfms_pkg::S_TRAIL : gfms_pkg::S_IDLE;
        end
      end
      gfms_pkg::S_TRAIL: begin
        // empty count: the state idles without issuing so the accumulator can settle
        cmd.sel = gfms_pkg::SEL_TRAIL;
        if (st.pend_zero) begin
          state_nxt = gfms_pkg::S_MAX;
        end else if (st.out_free) begin
          cmd.issue = 1'b1;
        end
      end
      gfms_pkg::S_MAX: begin
        cmd.sel      = gfms_pkg::SEL_MAX;
        cmd.end_flag = 1'b1;
        if (st.out_free) begin
          cmd.issue = 1'b1;
          state_nxt = gfms_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gfms_pkg::S_IDLE;
      end
    endcase
  end

  // checks
  `include "gap_fill_max_subarray_core_assert.svh"

  `GFMS_ASSERT_IMP(a_issue_free, cmd.issue, st.out_free)
  `GFMS_ASSERT_IMP(a_fill_nonempty, state_r == gfms_pkg::S_FILL, !st.pend_zero)
  `GFMS_ASSERT_NXT(a_trail_to_max, state_r == gfms_pkg::S_TRAIL && st.pend_zero, state_r == gfms_pkg::S_MAX)
  `GFMS_ASSERT_NXT(a_max_to_idle, state_r == gfms_pkg::S_MAX && cmd.issue, state_r == gfms_pkg::S_IDLE && st.pend_zero)

endmodule

`default_nettype wire

FILE: src/gfms_dp.sv
// ---------------------------------------------------------------------------
// gfms_dp
// Datapath: sample hold, pending gap counter, fill averaging, result register
// and the saturating maximum subarray accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module gfms_dp #(
  parameter int MAX_GAP     = gfms_pkg::MAX_GAP,
  parameter int SAMPLE_BITS = gfms_pkg::SAMPLE_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire gfms_pkg::cmd_t                        cmd,
  input  wire logic signed [gfms_pkg::SAMPLE_W-1:0] in_sample,
  output gfms_pkg::status_t                          st,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [gfms_pkg::VALUE_W-1:0]       out_value,
  output logic [gfms_pkg::KIND_W-1:0]               out_kind,
  output logic                                       out_end
);

  localparam int CntW = $clog2(MAX_GAP + 1);
  localparam int SumW = gfms_pkg::VALUE_W;
  localparam int ExtW = SumW - SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] left_r, left_nxt;
  logic                          left_valid_r, left_valid_nxt;
  logic [CntW-1:0]               pend_r, pend_nxt;

  logic signed [SAMPLE_BITS:0]   pair_sum;
  logic signed [SAMPLE_BITS:0]   pair_half;
  logic                          pair_round;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic signed [SAMPLE_BITS-1:0] rec_v;
  logic                          is_rec;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SumW-1:0]        out_value_r, out_value_nxt;
  gfms_pkg::kind_t               out_kind_r, out_kind_nxt;
  logic                          out_end_r;

  logic                          acc_go_r;
  logic signed [SumW-1:0]        acc_v_r;
  logic signed [SumW-1:0]        run_r, run_nxt;
  logic signed [SumW-1:0]        best_r, best_nxt;
  logic                          seen_r, seen_nxt;
  logic signed [SumW:0]          run_add;
  logic signed [SumW-1:0]        run_sat;
  logic                          clear;

  // status to the sequencer
  assign st.pend_zero = (pend_r == '0);
  assign st.pend_one  = (pend_r == CntW'(1));
  assign st.pend_full = (pend_r == CntW'(MAX_GAP));
  assign st.out_free  = !out_valid_r || out_ready;

  assign clear = cmd.issue && (cmd.sel == gfms_pkg::SEL_MAX);

  // held sample, low bits taken as a signed value
  always_ff @(posedge clk) begin
    if (cmd.load) sample_r <= in_sample[SAMPLE_BITS-1:0];
  end

  // midpoint of left value and sample, truncated toward zero
  always_comb begin
    pair_sum   = {left_r[SAMPLE_BITS-1], left_r} + {sample_r[SAMPLE_BITS-1], sample_r};
    pair_half  = pair_sum >>> 1;
    pair_round = pair_sum[SAMPLE_BITS] & pair_sum[0];
    avg        = pair_half[SAMPLE_BITS-1:0] + {{(SAMPLE_BITS-1){1'b0}}, pair_round};
  end

  // recovered value select and result word
  always_comb begin
    rec_v        = sample_r;
    is_rec       = 1'b1;
    out_kind_nxt = gfms_pkg::KIND_SAMPLE;
    case (cmd.sel)
      gfms_pkg::SEL_FILL:   rec_v = left_valid_r ? avg : sample_r;
      gfms_pkg::SEL_SAMPLE: rec_v = sample_r;
      gfms_pkg::SEL_TRAIL:  rec_v = left_valid_r ? left_r : '0;
      gfms_pkg::SEL_MAX: begin
        is_rec       = 1'b0;
        out_kind_nxt = gfms_pkg::KIND_MAX;
      end
      gfms_pkg::SEL_ERR: begin
        is_rec       = 1'b0;
        out_kind_nxt = gfms_pkg::KIND_ERR;
      end
      default: is_rec = 1'b0;
    endcase
    if (is_rec) begin
      out_value_nxt = {{ExtW{rec_v[SAMPLE_BITS-1]}}, rec_v};
    end else if (cmd.sel == gfms_pkg::SEL_MAX) begin
      out_value_nxt = seen_r ? best_r : '0;
    end else begin
      out_value_nxt = '0;
    end
  end

  // left neighbor and gap count
  always_comb begin
    left_nxt       = left_r;
    left_valid_nxt = left_valid_r;
    pend_nxt       = pend_r;
    if (cmd.pend_inc) pend_nxt = pend_r + CntW'(1);
    if (cmd.issue && is_rec) begin
      left_nxt       = rec_v;
      left_valid_nxt = 1'b1;
      if (cmd.sel != gfms_pkg::SEL_SAMPLE) pend_nxt = pend_r - CntW'(1);
    end
    if (clear) begin
      left_valid_nxt = 1'b0;
      pend_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      left_valid_r <= 1'b0;
      pend_r       <= '0;
    end else begin
      left_r       <= left_nxt;
      left_valid_r <= left_valid_nxt;
      pend_r       <= pend_nxt;
    end
  end

  // result register
  assign out_valid_nxt = cmd.issue ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      out_value_r <= out_value_nxt;
      out_kind_r  <= out_kind_nxt;
      out_end_r   <= cmd.end_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_kind  = out_kind_r;
  assign out_end   = out_end_r;

  // accumulator input stage, registered together with the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_go_r <= 1'b0;
    end else begin
      acc_go_r <= cmd.issue && is_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue && is_rec) acc_v_r <= out_value_nxt;
  end

  // kadane step with saturating running sum
  always_comb begin
    run_add = {run_r[SumW-1], run_r} + {acc_v_r[SumW-1], acc_v_r};
    if (run_add[SumW] != run_add[SumW-1]) begin
      run_sat = run_add[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      run_sat = run_add[SumW-1:0];
    end
    run_nxt  = run_r;
    best_nxt = best_r;
    seen_nxt = seen_r;
    if (acc_go_r) begin
      if (!seen_r) begin
        run_nxt  = acc_v_r;
        best_nxt = acc_v_r;
        seen_nxt = 1'b1;
      end else begin
        run_nxt  = run_r[SumW-1] ? acc_v_r : run_sat;
        best_nxt = (best_r < run_nxt) ? run_nxt : best_r;
      end
    end
    if (clear) begin
      run_nxt  = '0;
      best_nxt = '0;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      best_r <= '0;
      seen_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      best_r <= best_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/gap_fill_max_subarray_core.sv
// ---------------------------------------------------------------------------
// gap_fill_max_subarray_core
// Recovers missing samples by midpoint fill and reports the maximum subarray
// sum of the recovered sequence at the end of each run.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid / ready  sample[31:0] signed, missing, last
//   out_ch   out  valid / ready  value[47:0] signed, kind[1:0], end_of_run
//
// A word is taken while the sequencer is idle; it then issues one result per
// cycle while the result register is free: a present sample after k pending
// gaps gives k + 1 results, its fills and then the sample itself.
// A last word adds one result per trailing gap, a settle step for the
// accumulator and then the maximum sum result.
// A missing word that only extends the gap gives no result.
// Reset is synchronous, active low, and empties the gap count and accumulator.
// A low out_ch.ready holds the result register and the sequencer waits.
// ---------------------------------------------------------------------------
`default_nettype none

module gap_fill_max_subarray_core #(
  parameter int MAX_GAP     = gfms_pkg::MAX_GAP,
  parameter int SAMPLE_BITS = gfms_pkg::SAMPLE_BITS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  gfms_in_if.sink   in_ch,
  gfms_out_if.source out_ch
);

  gfms_pkg::cmd_t    cmd;
  gfms_pkg::status_t st;
  logic              in_ready;

  // sequencer
  gfms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_missing (in_ch.missing),
    .in_last    (in_ch.last),
    .in_ready   (in_ready),
    .st         (st),
    .cmd        (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath
  gfms_dp #(
    .MAX_GAP     (MAX_GAP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_sample (in_ch.sample),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.value),
    .out_kind  (out_ch.kind),
    .out_end   (out_ch.end_of_run)
  );

endmodule

`default_nettype wire

FILE: sim/gap_fill_max_subarray_core_test.sv
// ---------------------------------------------------------------------------
// gap_fill_max_subarray_core_test
// Drives sample words with random gaps and back-pressure into the core,
// predicts every recovered sample, gap error and maximum sum in the
// testbench, and checks each result word in order against the prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module gap_fill_max_subarray_core_test;

  localparam int CLK_PERIOD = 4;
  localparam int RAND_WORDS = 270;
  localparam int SQUEEZE_CYCLES = 300;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  // one input word with the idle cycles that precede it
  typedef struct {
    logic signed [gfms_pkg::SAMPLE_W-1:0] sample;
    logic                                 missing;
    logic                                 last;
    int                                   gap;
  } sample_word_t;

  // one predicted result word
  typedef struct {
    logic signed [gfms_pkg::VALUE_W-1:0] value;
    gfms_pkg::kind_t                     kind;
    logic                                eor;
  } recovered_t;

  logic clk = 1'b0;
  logic rst_n;

  gfms_in_if  in_ch ();
  gfms_out_if out_ch ();

  gap_fill_max_subarray_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  sample_word_t sample_q[$];
  recovered_t   recovered_q[$];
  sample_word_t next_word;
  recovered_t   want;

  int   n_words      = 0;
  int   words_taken  = 0;
  int   results_seen = 0;
  int   errors       = 0;
  int   gap_waited   = 0;
  logic in_taken     = 1'b0;

  // receiver pacing
  int   rx_left      = 0;
  logic rx_mode      = 1'b0;
  int   squeeze_left = 0;
  logic squeezed     = 1'b0;

  // predicted state of the recovery and accumulator
  logic signed [gfms_pkg::SAMPLE_W-1:0] left_val = '0;
  logic   left_ok  = 1'b0;
  int     pend     = 0;
  longint run_acc  = 0;
  longint best_acc = 0;
  logic   acc_seen = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  task automatic clear_recovery();
    left_val = '0;
    left_ok  = 1'b0;
    pend     = 0;
    run_acc  = 0;
    best_acc = 0;
    acc_seen = 1'b0;
  endtask

  // emit one recovered sample and fold it into the max subarray sum
  task automatic take_value(input longint v, ref recovered_t batch[$]);
    longint s;
    batch.push_back('{v[gfms_pkg::VALUE_W-1:0], gfms_pkg::KIND_SAMPLE, 1'b0});
    if (!acc_seen) begin
      run_acc  = v;
      best_acc = v;
      acc_seen = 1'b1;
    end else begin
      if (run_acc < 0) begin
        run_acc = v;
      end else begin
        s = run_acc + v;
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        run_acc = s;
      end
      if (best_acc < run_acc) best_acc = run_acc;
    end
    left_val = v[gfms_pkg::SAMPLE_W-1:0];
    left_ok  = 1'b1;
  endtask

  task automatic recover_word(input logic signed [gfms_pkg::SAMPLE_W-1:0] smp,
                              input logic miss, input logic lst);
    recovered_t batch[$];
    longint s;
    longint v;
    longint mx;
    if (miss) begin
      // gap grows until full, then each extra missing word is an error
      if (pend < gfms_pkg::MAX_GAP) pend++;
      else batch.push_back('{'0, gfms_pkg::KIND_ERR, 1'b0});
    end else begin
      // midpoint fill toward the present sample, or copy it on a leading gap
      s = smp;
      while (pend > 0) begin
        v = left_ok ? (longint'(left_val) + s) / 2 : s;
        take_value(v, batch);
        pend--;
      end
      take_value(s, batch);
    end
    if (lst) begin
      // trailing gap repeats the left value, all-missing gives zeros
      while (pend > 0) begin
        v = left_ok ? longint'(left_val) : 0;
        take_value(v, batch);
        pend--;
      end
      mx = acc_seen ? best_acc : 0;
      batch.push_back('{mx[gfms_pkg::VALUE_W-1:0], gfms_pkg::KIND_MAX, 1'b0});
      clear_recovery();
    end
    if (batch.size() > 0) batch[batch.size() - 1].eor = 1'b1;
    foreach (batch[k]) recovered_q.push_back(batch[k]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [gfms_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 200) - 100;
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(input logic signed [gfms_pkg::SAMPLE_W-1:0] smp, input logic miss,
                          input logic lst, input int gap);
    sample_q.push_back('{smp, miss, lst, gap});
    n_words++;
  endtask

  task automatic add_present(input logic signed [gfms_pkg::SAMPLE_W-1:0] smp,
                             input logic lst);
    add_word(smp, 1'b0, lst, rand_gap());
  endtask

  task automatic add_missing(input logic lst);
    add_word(rand_sample(), 1'b1, lst, rand_gap());
  endtask

  // ---------------------------------------------------------------------------
  // input driver: next word at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (sample_q.size() > 0 && gap_waited >= sample_q[0].gap) begin
        next_word = sample_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= next_word.sample;
        in_ch.missing <= next_word.missing;
        in_ch.last    <= next_word.last;
        gap_waited    <= 0;
      end else begin
        in_ch.valid <= 1'b0;
        if (sample_q.size() > 0) gap_waited <= gap_waited + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, calm stretches and one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!squeezed && results_seen >= 10) begin
      squeezed     <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_left > 0) begin
      rx_left      <= rx_left - 1;
      out_ch.ready <= rx_mode;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          rx_mode      <= 1'b1;
          rx_left      <= $urandom_range(30, 150);
          out_ch.ready <= 1'b1;
        end
        3: begin
          rx_mode      <= 1'b0;
          rx_left      <= $urandom_range(10, 40);
          out_ch.ready <= 1'b0;
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each taken word, check each result word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        recover_word(in_ch.sample, in_ch.missing, in_ch.last);
        words_taken <= words_taken + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (recovered_q.size() == 0) begin
          $error("unexpected result word: value %0d kind %0d end_of_run %0b",
                 out_ch.value, out_ch.kind, out_ch.end_of_run);
          errors++;
        end else begin
          want = recovered_q.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.value);
            errors++;
          end
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
            errors++;
          end
          if (out_ch.end_of_run !== want.eor) begin
            $error("end_of_run: expected %0b, got %0b", want.eor, out_ch.end_of_run);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    int seq_len;
    int gap_len;
    int calm;
    logic end_on_gap;
    rst_n = 1'b0;

    // extremes as single-word runs
    add_present(32'h7fff_ffff, 1'b1);
    add_present(32'h8000_0000, 1'b1);
    // leading gap, then a midpoint fill
    add_missing(1'b0);
    add_missing(1'b0);
    add_present(100, 1'b0);
    add_present(-7, 1'b0);
    add_missing(1'b0);
    add_present(50, 1'b1);
    // trailing gap
    add_present(5, 1'b0);
    add_missing(1'b0);
    add_missing(1'b1);
    // all missing
    add_missing(1'b0);
    add_missing(1'b0);
    add_missing(1'b1);
    // rounding toward zero on negative midpoints and across the full range
    add_present(-3, 1'b0);
    add_missing(1'b0);
    add_present(0, 1'b0);
    add_present(32'h8000_0000, 1'b0);
    add_missing(1'b0);
    add_present(32'h7fff_ffff, 1'b1);
    // lone missing word, and a zero after minus one
    add_missing(1'b1);
    add_present(-1, 1'b0);
    add_present(0, 1'b1);

    // gap overflow ended by a present word, then ended by a missing last word
    for (int j = 0; j < gfms_pkg::MAX_GAP + 2; j++) add_missing(1'b0);
    add_present(9, 1'b1);
    add_present(4, 1'b0);
    for (int j = 0; j < gfms_pkg::MAX_GAP + 1; j++) add_missing(j == gfms_pkg::MAX_GAP);

    // random runs: mostly well-formed with short gaps, some long gaps and noise
    gap_len = n_words + RAND_WORDS;
    while (n_words < gap_len) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        seq_len = $urandom_range(1, 12);
        for (int j = 0; j < seq_len; j++)
          add_word(rand_sample(), $urandom_range(0, 2) == 0, j == seq_len - 1,
                   calm ? 0 : rand_gap());
      end else if (pick < 83) begin
        seq_len = $urandom_range(gfms_pkg::MAX_GAP - 2, gfms_pkg::MAX_GAP + 4);
        end_on_gap = ($urandom_range(0, 1) != 0);
        if ($urandom_range(0, 1)) add_present(rand_sample(), 1'b0);
        for (int j = 0; j < seq_len; j++)
          add_word(rand_sample(), 1'b1, end_on_gap && j == seq_len - 1,
                   calm ? 0 : rand_gap());
        if (!end_on_gap) add_present(rand_sample(), 1'b1);
      end else if (pick < 90) begin
        seq_len = $urandom_range(1, 5);
        for (int j = 0; j < seq_len; j++) add_missing(j == seq_len - 1);
      end else begin
        seq_len = $urandom_range(1, 8);
        for (int j = 0; j < seq_len; j++)
          add_word($urandom, ($urandom_range(0, 1) != 0), ($urandom_range(0, 1) != 0),
                   calm ? 0 : rand_gap());
      end
    end
    // close whatever run is still open
    add_present(rand_sample(), 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // drain: all words taken, all results seen, then a short settle
    while (words_taken < n_words) @(negedge clk);
    while (recovered_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("gap_fill_max_subarray_core test passed");
    end else begin
      $display("gap_fill_max_subarray_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("gap_fill_max_subarray_core test failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/gfms_pkg.sv
src/gfms_in_if.sv
src/gfms_out_if.sv
src/gfms_ctrl.sv
src/gfms_dp.sv
src/gap_fill_max_subarray_core.sv
sim/gap_fill_max_subarray_core_test.sv
